// ===== rtl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the character class tokenizer
// Record and state structures, byte class helpers and result queue sizing.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int MAX_TOKEN_BYTES = 255;
    localparam logic [7:0]  KEEP_LIMIT = 8'(MAX_TOKEN_BYTES - 1);
    localparam logic [31:0] POS_MAX    = 32'hFFFF_FFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Record kinds
    localparam logic REC_BYTE = 1'b0;
    localparam logic REC_END  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SPLIT_MODE = 1'b0;
    localparam logic CFG_LOWERCASE  = 1'b1;

    // Split modes
    localparam logic SPLIT_SPACE  = 1'b0;
    localparam logic SPLIT_LETTER = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tbyte;
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic [7:0]  kept_len;
        logic        last;
    } t_rec;

    typedef struct packed {
        logic        in_token;
        logic [31:0] pos;
        logic [31:0] start_off;
        logic [7:0]  kept;
        logic        finished;
    } t_tok_state;

    function automatic logic is_space_byte(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_upper_byte(input logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5A);
    endfunction

    function automatic logic is_letter_byte(input logic [7:0] b);
        return is_upper_byte(b) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

endpackage

// ===== rtl/cct_step.sv =====
// ----------------------------------------------------------------------------
// cct_step: per-byte tokenizer logic
// Classifies one text byte, forms up to two records and the next state.
// ----------------------------------------------------------------------------
module cct_step (
    input  cct_pkg::t_tok_state i_state,
    input  logic [7:0]          i_text_byte,
    input  logic                i_end_of_text,
    input  logic                i_split_mode,
    input  logic                i_lowercase,
    output cct_pkg::t_tok_state o_next_state,
    output cct_pkg::t_rec       o_rec0,
    output cct_pkg::t_rec       o_rec1,
    output logic [1:0]          o_push_n
);
    import cct_pkg::*;

    logic        tok;
    logic        active;
    logic [31:0] pos_inc;
    logic [31:0] tok_start;
    logic [7:0]  kc_base;
    logic        emit_byte;
    logic [7:0]  kc_new;
    logic [7:0]  out_byte;
    logic        emit_end;
    t_rec        rec_byte;
    t_rec        rec_end;
    t_tok_state  st;

    always_comb begin
        active = !i_state.finished;
        if (i_text_byte == 8'd0) begin
            tok = 1'b0;
        end else if (i_split_mode == SPLIT_LETTER) begin
            tok = is_letter_byte(i_text_byte);
        end else begin
            tok = !is_space_byte(i_text_byte);
        end

        pos_inc   = (i_state.pos == POS_MAX) ? POS_MAX : i_state.pos + 32'd1;
        tok_start = i_state.in_token ? i_state.start_off : i_state.pos;
        kc_base   = i_state.in_token ? i_state.kept : 8'd0;
        emit_byte = active && tok && (kc_base < KEEP_LIMIT);
        kc_new    = kc_base + {7'd0, emit_byte};
        out_byte  = i_text_byte;
        if (i_lowercase && is_upper_byte(i_text_byte)) begin
            out_byte = i_text_byte + 8'h20;
        end

        // A token closes on a non-token byte, or on the final byte of the text.
        emit_end = active && (tok ? i_end_of_text : i_state.in_token);

        rec_byte.kind      = REC_BYTE;
        rec_byte.tbyte     = out_byte;
        rec_byte.start_off = tok_start;
        rec_byte.end_off   = 32'd0;
        rec_byte.kept_len  = kc_new;
        rec_byte.last      = !emit_end;

        rec_end.kind      = REC_END;
        rec_end.tbyte     = 8'd0;
        rec_end.start_off = tok ? tok_start : i_state.start_off;
        rec_end.end_off   = tok ? pos_inc : i_state.pos;
        rec_end.kept_len  = tok ? kc_new : i_state.kept;
        rec_end.last      = 1'b1;

        o_rec0   = emit_byte ? rec_byte : rec_end;
        o_rec1   = rec_end;
        o_push_n = {1'b0, emit_byte} + {1'b0, emit_end};

        st = i_state;
        if (active) begin
            if (tok) begin
                st.in_token  = 1'b1;
                st.start_off = tok_start;
                st.kept      = kc_new;
                st.pos       = pos_inc;
            end else begin
                st.in_token = 1'b0;
                if (i_text_byte == 8'd0) begin
                    st.finished = 1'b1;
                end else begin
                    st.pos = pos_inc;
                end
            end
        end
        if (i_end_of_text) begin
            st = '0;
        end
        o_next_state = st;
    end

endmodule

// ===== rtl/cct_result_fifo.sv =====
// ----------------------------------------------------------------------------
// cct_result_fifo: result record queue
// Takes up to two records a cycle and hands out one a cycle.
// ----------------------------------------------------------------------------
module cct_result_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_n,
    input  cct_pkg::t_rec i_rec0,
    input  cct_pkg::t_rec i_rec1,
    input  logic          i_pop,
    output logic          o_room,
    output logic          o_valid,
    output cct_pkg::t_rec o_rec
);
    import cct_pkg::*;

    t_rec               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_AW-1:0] wptr_1;
    logic               pop;

    assign wptr_1  = r_wptr + FIFO_AW'(1);
    assign o_valid = (r_count != '0);
    assign pop     = i_pop && o_valid;
    // Room for a full pair of records, judged before this cycle's pop.
    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_rec   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wptr] <= i_rec0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wptr_1] <= i_rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + FIFO_AW'(i_push_n);
            r_rptr  <= r_rptr + FIFO_AW'(pop);
            r_count <= r_count + FIFO_CW'(i_push_n) - FIFO_CW'(pop);
        end
    end

endmodule

// ===== rtl/char_class_tokenizer.sv =====
// ----------------------------------------------------------------------------
// char_class_tokenizer: whitespace and letter tokenizer
// Splits a byte stream into token byte records and token end records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one text byte and an end of
//   text flag per item. Output channel (o_valid / i_ready) carries one record
//   per item: a token byte record or a token end record, with o_last_of_run
//   set on the last record caused by an input byte.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle; it applies from the next byte.
//   A record passes through the input register and the result queue
//   before it can be taken. Throughput: one byte per cycle while each
//   byte yields at most one record and the receiver takes them; a byte
//   with two records waits on the single read port of the four-entry queue.
//   Reset clears the tokenizer state, the configuration and the queue.
//   When the receiver stalls, the queue fills; the input register then
//   holds its byte and o_ready falls until the queue has room for two
//   records.
// ----------------------------------------------------------------------------
module char_class_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_record_kind,
    output logic [7:0]  o_token_byte,
    output logic [31:0] o_start_offset,
    output logic [31:0] o_end_offset,
    output logic [7:0]  o_kept_length,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);
    import cct_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_text_byte;
    logic       r_end_of_text;
    logic       r_split_mode;
    logic       r_lowercase;
    t_tok_state r_state;
    t_tok_state n_state;
    t_rec       rec0;
    t_rec       rec1;
    t_rec       out_rec;
    logic [1:0] push_raw;
    logic [1:0] push_n;
    logic       room;
    logic       stage_go;

    assign stage_go = r_in_valid && room;
    assign o_ready  = !r_in_valid || stage_go;
    assign push_n   = stage_go ? push_raw : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_text_byte   <= i_text_byte;
            r_end_of_text <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode <= SPLIT_SPACE;
            r_lowercase  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPLIT_MODE: r_split_mode <= i_cfg_data;
                CFG_LOWERCASE:  r_lowercase  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (stage_go) begin
            r_state <= n_state;
        end
    end

    cct_step u_step (
        .i_state       (r_state),
        .i_text_byte   (r_text_byte),
        .i_end_of_text (r_end_of_text),
        .i_split_mode  (r_split_mode),
        .i_lowercase   (r_lowercase),
        .o_next_state  (n_state),
        .o_rec0        (rec0),
        .o_rec1        (rec1),
        .o_push_n      (push_raw)
    );

    cct_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_rec0   (rec0),
        .i_rec1   (rec1),
        .i_pop    (i_ready),
        .o_room   (room),
        .o_valid  (o_valid),
        .o_rec    (out_rec)
    );

    assign o_record_kind  = out_rec.kind;
    assign o_token_byte   = out_rec.tbyte;
    assign o_start_offset = out_rec.start_off;
    assign o_end_offset   = out_rec.end_off;
    assign o_kept_length  = out_rec.kept_len;
    assign o_last_of_run  = out_rec.last;

endmodule

// ===== rtl/cct_checker.sv =====
// ----------------------------------------------------------------------------
// cct_checker: port-level checks of the tokenizer
// Record shape rules and output stall behaviour, bound to the top level.
// ----------------------------------------------------------------------------
module cct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_record_kind,
    input logic [7:0]  o_token_byte,
    input logic [31:0] o_start_offset,
    input logic [31:0] o_end_offset,
    input logic [7:0]  o_kept_length,
    input logic        o_last_of_run
);
    import cct_pkg::*;

    // A token byte record never carries an end offset and always counts itself.
    a_byte_rec_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_kind == REC_BYTE) |->
            (o_end_offset == 32'd0 && o_kept_length != 8'd0))
        else $error("token byte record has bad end offset or length");

    a_end_rec_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_kind == REC_END) |-> (o_token_byte == 8'd0))
        else $error("token end record carries a byte");

    // An end record always closes its run, so it is marked last of run.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_kind == REC_END) |-> o_last_of_run)
        else $error("token end record not marked last");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_record_kind) && $stable(o_token_byte) &&
             $stable(o_start_offset) && $stable(o_end_offset) &&
             $stable(o_kept_length) && $stable(o_last_of_run)))
        else $error("output record changed while stalled");

endmodule

bind char_class_tokenizer cct_checker u_cct_checker (.*);
